@@ hw/rtl/srl_pkg.sv @@
// Shared types and constants for the S-record loader parser.
package srl_pkg;

  // ASCII 'S', the record lead-in
  localparam logic [7:0] CharS = 8'h53;

  // Depth of the queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  // Width of the address field on the result channel
  localparam int unsigned AddrOutW = 32;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_e;

  // One received character, already classified by the front
  typedef struct packed {
    logic       is_s;        // character is 'S'
    logic [2:0] type_len;    // address bytes for a type digit, 0 if not a type digit
    logic [3:0] type_digit;  // digit value when type_len is nonzero
    logic [3:0] nib;         // hex nibble value, 0 for a non-hex character
  } token_t;

  // Queue head as seen by the back
  typedef struct packed {
    logic   valid;
    token_t tok;
  } q_head_t;

endpackage

@@ hw/rtl/srl_front.sv @@
// Front: input handshake and character classification.
module srl_front (
  input  logic          in_valid_i,
  input  logic [7:0]    rx_char_i,
  input  logic          q_full_i,
  output logic          in_stall_o,
  output logic          push_o,
  output srl_pkg::token_t tok_o
);
  import srl_pkg::*;

  logic [3:0] lo;

  assign lo         = rx_char_i[3:0];
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    tok_o            = '0;
    tok_o.is_s       = (rx_char_i == CharS);
    tok_o.type_digit = lo;
    unique case (rx_char_i)
      "0", "1", "5", "9": tok_o.type_len = 3'd2;
      "2", "8":           tok_o.type_len = 3'd3;
      "3", "7":           tok_o.type_len = 3'd4;
      default:            tok_o.type_len = 3'd0;
    endcase
    // decode hex: digits map to the low nibble, letters to low nibble plus nine
    if (rx_char_i >= "0" && rx_char_i <= "9") begin
      tok_o.nib = lo;
    end else if ((rx_char_i >= "A" && rx_char_i <= "F") ||
                 (rx_char_i >= "a" && rx_char_i <= "f")) begin
      tok_o.nib = lo + 4'd9;
    end else begin
      tok_o.nib = 4'd0;
    end
  end

endmodule

@@ hw/rtl/srl_fifo.sv @@
// Short token queue between front and back.
module srl_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  srl_pkg::token_t tok_i,
  input  logic            pop_i,
  output logic            full_o,
  output srl_pkg::q_head_t head_o
);
  import srl_pkg::*;

  token_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o       = (cnt_q == QCntW'(QDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.tok   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ hw/rtl/srl_back.sv @@
// Back: S-record parser state machine and result register.
module srl_back #(
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  srl_pkg::q_head_t         head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output srl_pkg::kind_e           kind_o,
  output logic [ADDR_WIDTH-1:0]    address_o,
  output logic [7:0]               data_byte_o,
  output logic [3:0]               record_type_o,
  output logic                     checksum_ok_o,
  output logic                     commit_o,
  output logic                     jump_o
);
  import srl_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TYPE, PH_COUNT, PH_ADDR, PH_DATA, PH_CRC, PH_TERM
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [3:0]            rec_type_q, rec_type_d;
  logic [2:0]            addr_bytes_q, addr_bytes_d;
  logic                  char_fill_q, char_fill_d;
  logic [ADDR_WIDTH-1:0] addr_q, addr_d;
  logic [3:0]            high_q, high_d;
  logic [7:0]            data_left_q, data_left_d;
  logic [7:0]            data_index_q, data_index_d;
  logic [7:0]            sum_q, sum_d;

  logic                  out_valid_q, out_valid_d;
  kind_e                 kind_q, kind_d;
  logic [ADDR_WIDTH-1:0] out_addr_q, out_addr_d;
  logic [7:0]            byte_q, byte_d;
  logic [3:0]            otype_q, otype_d;
  logic                  ok_q, ok_d, commit_q, commit_d, jump_q, jump_d;

  token_t     tok;
  logic [7:0] pair;
  logic       pair_done;
  logic       ok;
  logic       addr_nz;

  assign tok       = head_i.tok;
  assign pop_o     = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pair      = {high_q, tok.nib};
  assign pair_done = char_fill_q;
  assign ok        = ((sum_q ^ 8'hFF) == pair);
  assign addr_nz   = (addr_q != '0);

  always_comb begin
    phase_d      = phase_q;
    rec_type_d   = rec_type_q;
    addr_bytes_d = addr_bytes_q;
    char_fill_d  = char_fill_q;
    addr_d       = addr_q;
    high_d       = high_q;
    data_left_d  = data_left_q;
    data_index_d = data_index_q;
    sum_d        = sum_q;

    out_valid_d  = out_valid_q && out_stall_i;
    kind_d       = kind_q;
    out_addr_d   = out_addr_q;
    byte_d       = byte_q;
    otype_d      = otype_q;
    ok_d         = ok_q;
    commit_d     = commit_q;
    jump_d       = jump_q;

    if (pop_o) begin
      out_valid_d = 1'b0;
      // pair assembly for every hex phase
      if (phase_q == PH_COUNT || phase_q == PH_ADDR ||
          phase_q == PH_DATA || phase_q == PH_CRC) begin
        char_fill_d = !char_fill_q;
        if (!char_fill_q) begin
          high_d = tok.nib;
        end
      end
      unique case (phase_q)
        PH_IDLE: begin
          if (tok.is_s) begin
            phase_d     = PH_TYPE;
            out_valid_d = 1'b1;
            kind_d      = KIND_START;
            out_addr_d  = '0;
            byte_d      = '0;
            otype_d     = '0;
            ok_d        = 1'b0;
            commit_d    = 1'b0;
            jump_d      = 1'b0;
          end
        end
        PH_TYPE: begin
          if (tok.type_len != '0) begin
            rec_type_d   = tok.type_digit;
            addr_bytes_d = tok.type_len;
            char_fill_d  = 1'b0;
            sum_d        = '0;
            addr_d       = '0;
            data_index_d = '0;
            phase_d      = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (pair_done) begin
            sum_d = sum_q + pair;
            if (pair > 8'(addr_bytes_q)) begin
              data_left_d = pair - 8'(addr_bytes_q) - 8'd1;
            end else begin
              data_left_d = '0;
            end
            phase_d = PH_ADDR;
          end
        end
        PH_ADDR: begin
          addr_d = {addr_q[ADDR_WIDTH-5:0], tok.nib};
          if (pair_done) begin
            sum_d        = sum_q + pair;
            addr_bytes_d = addr_bytes_q - 3'd1;
            if (addr_bytes_q == 3'd1) begin
              data_index_d = '0;
              if (rec_type_q <= 4'd3 && data_left_q != '0) begin
                phase_d = PH_DATA;
              end else begin
                phase_d = PH_CRC;
              end
            end
          end
        end
        PH_DATA: begin
          if (pair_done) begin
            sum_d        = sum_q + pair;
            data_index_d = data_index_q + 8'd1;
            data_left_d  = data_left_q - 8'd1;
            if (data_left_q == 8'd1) begin
              phase_d = PH_CRC;
            end
            out_valid_d = 1'b1;
            kind_d      = KIND_DATA;
            out_addr_d  = addr_q + ADDR_WIDTH'(data_index_q);
            byte_d      = pair;
            otype_d     = rec_type_q;
            ok_d        = 1'b0;
            commit_d    = 1'b0;
            jump_d      = 1'b0;
          end
        end
        PH_CRC: begin
          if (pair_done) begin
            phase_d     = PH_TERM;
            out_valid_d = 1'b1;
            kind_d      = KIND_VERDICT;
            out_addr_d  = addr_q;
            byte_d      = '0;
            otype_d     = rec_type_q;
            ok_d        = ok;
            commit_d    = ok && addr_nz && rec_type_q >= 4'd1 && rec_type_q <= 4'd3;
            jump_d      = ok && addr_nz && rec_type_q >= 4'd7 && rec_type_q <= 4'd9;
          end
        end
        default: begin
          // terminator: drop the character and clear the record state
          phase_d      = PH_IDLE;
          rec_type_d   = '0;
          addr_bytes_d = '0;
          char_fill_d  = 1'b0;
          addr_d       = '0;
          high_d       = '0;
          data_left_d  = '0;
          data_index_d = '0;
          sum_d        = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      rec_type_q   <= '0;
      addr_bytes_q <= '0;
      char_fill_q  <= 1'b0;
      addr_q       <= '0;
      high_q       <= '0;
      data_left_q  <= '0;
      data_index_q <= '0;
      sum_q        <= '0;
      out_valid_q  <= 1'b0;
      kind_q       <= KIND_START;
      out_addr_q   <= '0;
      byte_q       <= '0;
      otype_q      <= '0;
      ok_q         <= 1'b0;
      commit_q     <= 1'b0;
      jump_q       <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      rec_type_q   <= rec_type_d;
      addr_bytes_q <= addr_bytes_d;
      char_fill_q  <= char_fill_d;
      addr_q       <= addr_d;
      high_q       <= high_d;
      data_left_q  <= data_left_d;
      data_index_q <= data_index_d;
      sum_q        <= sum_d;
      out_valid_q  <= out_valid_d;
      kind_q       <= kind_d;
      out_addr_q   <= out_addr_d;
      byte_q       <= byte_d;
      otype_q      <= otype_d;
      ok_q         <= ok_d;
      commit_q     <= commit_d;
      jump_q       <= jump_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign address_o     = out_addr_q;
  assign data_byte_o   = byte_q;
  assign record_type_o = otype_q;
  assign checksum_ok_o = ok_q;
  assign commit_o      = commit_q;
  assign jump_o        = jump_q;

`ifndef SYNTHESIS
  a_flags_only_on_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q != KIND_VERDICT |-> !ok_q && !commit_q && !jump_q)
    else $error("verdict flags set on a non-verdict result");

  a_commit_jump_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(commit_q && jump_q))
    else $error("commit and jump both set");

  a_flag_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_q || jump_q) |-> ok_q)
    else $error("commit or jump without a good checksum");

  a_idle_pair_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> !char_fill_q)
    else $error("half pair left over in idle");

  a_no_pop_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !pop_o)
    else $error("token consumed while the result is held");
`endif

endmodule

@@ hw/rtl/srecord_loader_parser.sv @@
// Top level of the S-record loader parser: front, token queue and back.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  input    | in_valid_i / in_stall_o   | rx_char_i
//  output   | out_valid_o / out_stall_i | kind_o, address_o, data_byte_o,
//           |                           | record_type_o, checksum_ok_o,
//           |                           | commit_o, jump_o
//
// One character per cycle is sustained while the output is not stalled; the
// parser loop in the back retires one queued character each cycle while the
// result register is free or taken. A result passes through the queue and
// then the result register.
// Reset clears the queue, the parser state and the result register at once;
// there is no clearing pass.
// A stalled output only stops the back; the two-entry queue absorbs the
// front until it is full, and then in_stall_o rises.
module srecord_loader_parser #(
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] address_o,
  output logic [7:0]  data_byte_o,
  output logic [3:0]  record_type_o,
  output logic        checksum_ok_o,
  output logic        commit_o,
  output logic        jump_o
);
  import srl_pkg::*;

  // classified character from the front into the queue
  logic    push;
  token_t  tok;
  logic    q_full;

  // queue head into the back, and its consume strobe
  q_head_t head;
  logic    pop;

  kind_e                 kind;
  logic [ADDR_WIDTH-1:0] address;

  srl_front u_front (
    .in_valid_i (in_valid_i),
    .rx_char_i  (rx_char_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .tok_o      (tok)
  );

  srl_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .tok_i  (tok),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  // The back masks the address to ADDR_WIDTH bits by holding only that many.
  srl_back #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind),
    .address_o     (address),
    .data_byte_o   (data_byte_o),
    .record_type_o (record_type_o),
    .checksum_ok_o (checksum_ok_o),
    .commit_o      (commit_o),
    .jump_o        (jump_o)
  );

  assign kind_o    = kind;
  // zero-extend the masked address onto the full-width port
  assign address_o = AddrOutW'(address);

endmodule
